// ===== hdl/spsd_pkg.sv =====
// Shared constants and types for the streaming pair-sum detector.
`timescale 1ns / 1ps
`default_nettype none

package spsd_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_SIZE = 128;
    localparam int DEF_VALUE_BITS = 16;

    // Saturating occurrence count held in each table entry
    localparam int CNT_BITS = 2;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    // Set stamp kept next to each count; all-ones marks an entry wiped by a clearing
    // pass and is the stamp in use until the next new set
    localparam int EPOCH_BITS = 4;
    localparam logic [EPOCH_BITS-1:0] STAMP_NONE = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = STAMP_NONE - 1'b1;

    localparam int WORD_BITS = EPOCH_BITS + CNT_BITS;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Configuration register indexes
    typedef enum logic {
        REG_TARGET = 1'b0,
        REG_BIAS   = 1'b1
    } t_reg_idx;

    // Table maintenance state, one-hot
    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/streaming_pair_sum_detector.sv =====
// Streaming pair-sum detector: top level with count table and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input request: i_value (signed) and i_new_set on i_in_valid / o_in_ready.
//   Result request: o_pair_found, o_same_value, o_first_value, o_second_value,
//   o_out_of_range on o_out_valid / i_out_ready; exactly one result per input.
//   target_sum (byte address 0) and bias (byte address 4; 8 with 64-bit APB data)
//   are to be written over the APB port while the block is idle, which the block does not enforce; both read back.
// Timing
//   o_out_valid rises once an accepted request has left the stage-1 registers and
//   its result is in the result queue. One request per cycle is taken
//   while the result queue drains; the count table's single write port takes one
//   read-modify-write per request, with the last write forwarded into the
//   following lookup.
//   A new set is normally taken without a stall: a set stamp in each entry retires old
//   counts. A clearing pass leaves room for 15 new sets; the 16th finds the
//   stamps used up and waits for the next pass, which clears one entry per cycle.
// Reset
//   Reset empties the pipeline and the queue and starts the same clearing pass:
//   o_in_ready stays low until the pass has cleared every table entry.
// Stalls
//   A 4-deep result queue holds finished results; when the queued results and the
//   request in stage 1 would fill it, o_in_ready drops and the pipeline holds nothing back.

module streaming_pair_sum_detector #(
    parameter int TABLE_SIZE = spsd_pkg::DEF_TABLE_SIZE,
    parameter int VALUE_BITS = spsd_pkg::DEF_VALUE_BITS,
    // APB data is 64 bits once target_sum no longer fits in 32
    parameter int APB_DW     = (VALUE_BITS + 1 > 32) ? 64 : 32,
    parameter int APB_AW     = (APB_DW == 64) ? 4 : 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [APB_AW-1:0]            paddr,
    input  wire logic [APB_DW-1:0]            pwdata,
    output logic      [APB_DW-1:0]            prdata,
    output logic                              pready,
    // input requests
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic                         i_new_set,
    // result requests
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_pair_found,
    output logic                              o_same_value,
    output logic signed [VALUE_BITS-1:0]      o_first_value,
    output logic signed [VALUE_BITS:0]        o_second_value,
    output logic                              o_out_of_range
);

    import spsd_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    // complement index reaches about 2.5 * 2^VB in magnitude
    localparam int SUM_W  = VB + 3;
    localparam int CMP_W  = (SUM_W > IDX_W + 2) ? SUM_W : IDX_W + 2;
    localparam int RES_W  = VB + (VB + 1) + 3;
    localparam logic signed [CMP_W-1:0] TBL_LIM = CMP_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [VB:0]   r_target;
    logic [VB-1:0] r_bias;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_bias   <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[APB_AW-1]))
                REG_TARGET: r_target <= pwdata[VB:0];
                REG_BIAS:   r_bias   <= pwdata[VB-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[APB_AW-1]))
            REG_TARGET: prdata = APB_DW'(r_target);
            REG_BIAS:   prdata = APB_DW'(r_bias);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_sweep_addr;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic                  need_sweep;
    logic                  room;
    logic                  in_acc;

    // result queue
    logic [RES_W-1:0]      r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wp, r_rp;
    logic [OQ_PTR_W:0]     r_cnt;
    logic                  q_pop;

    // stage 1: table words arrive from the RAM
    logic                  r_s1_valid;
    logic signed [VB-1:0]  r_s1_value;
    logic [VB:0]           r_s1_comp;
    logic [IDX_W-1:0]      r_s1_idx, r_s1_cidx;
    logic                  r_s1_in_a, r_s1_in_b;
    logic [EPOCH_BITS-1:0] r_s1_epoch;

    // last table write, forwarded into the lookup that missed it
    logic                  r_fw_valid;
    logic [IDX_W-1:0]      r_fw_addr;
    logic [WORD_BITS-1:0]  r_fw_word;

    // The stamps are exhausted: a new set must wait for a clearing pass.
    assign need_sweep = i_new_set && (r_epoch == EPOCH_LAST);
    // Credit for the queue counts the request already in stage 1.
    assign room       = (r_cnt + {{OQ_PTR_W{1'b0}}, r_s1_valid}) < (OQ_PTR_W + 1)'(OQ_DEPTH);
    assign o_in_ready = (r_state == ST_RUN) && room && !need_sweep;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (i_in_valid && need_sweep && !r_s1_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_sweep_addr == IDX_LAST) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // A new set moves to a fresh stamp. A clearing pass parks the stamp at
    // all-ones, so the new set that follows it wraps to zero.
    always_comb begin
        n_epoch = r_epoch;
        if (r_state == ST_SWEEP) begin
            n_epoch = STAMP_NONE;
        end else if (in_acc && i_new_set) begin
            n_epoch = (r_epoch == EPOCH_LAST) ? '0 : r_epoch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_epoch      <= '0;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            if (r_state == ST_SWEEP) begin
                r_sweep_addr <= (r_sweep_addr == IDX_LAST) ? '0 : r_sweep_addr + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: index and complement index, RAM reads
    // ------------------------------------------------------------------
    logic signed [CMP_W-1:0] v_x, b_x, t_x;
    logic signed [CMP_W-1:0] idx_s, comp_s, cidx_s;
    logic                    in_a, in_b;

    assign v_x    = {{(CMP_W - VB){i_value[VB-1]}}, i_value};
    assign b_x    = {{(CMP_W - VB){1'b0}}, r_bias};
    assign t_x    = {{(CMP_W - VB - 1){r_target[VB]}}, r_target};
    assign idx_s  = v_x + b_x;
    assign comp_s = t_x - v_x;
    assign cidx_s = comp_s + b_x;
    assign in_a   = !idx_s[CMP_W-1]  && (idx_s  < TBL_LIM);
    assign in_b   = !cidx_s[CMP_W-1] && (cidx_s < TBL_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_value <= i_value;
            r_s1_comp  <= comp_s[VB:0];
            r_s1_idx   <= idx_s[IDX_W-1:0];
            r_s1_cidx  <= cidx_s[IDX_W-1:0];
            r_s1_in_a  <= in_a;
            r_s1_in_b  <= in_b;
            r_s1_epoch <= n_epoch;
        end
    end

    // ------------------------------------------------------------------
    // Count table
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] rd_a, rd_b;

    logic [WORD_BITS-1:0] word_a, word_b;
    logic [CNT_BITS-1:0]  cnt_a, cnt_b, new_cnt;
    logic                 s1_wr;
    logic                 pair, same;

    spsd_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (idx_s[IDX_W-1:0]),
        .i_raddr_b (cidx_s[IDX_W-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // ------------------------------------------------------------------
    // Stage 1: count update and complement check
    // ------------------------------------------------------------------
    assign word_a = (r_fw_valid && (r_fw_addr == r_s1_idx))  ? r_fw_word : rd_a;
    assign word_b = (r_fw_valid && (r_fw_addr == r_s1_cidx)) ? r_fw_word : rd_b;

    // an entry stamped with another set counts as empty
    assign cnt_a = (word_a[WORD_BITS-1:CNT_BITS] == r_s1_epoch) ? word_a[CNT_BITS-1:0] : '0;
    assign cnt_b = (word_b[WORD_BITS-1:CNT_BITS] == r_s1_epoch) ? word_b[CNT_BITS-1:0] : '0;
    assign new_cnt = (cnt_a == CNT_MAX) ? CNT_MAX : cnt_a + 1'b1;

    assign s1_wr = r_s1_valid && r_s1_in_a;

    always_comb begin
        pair = 1'b0;
        same = 1'b0;
        if (r_s1_in_b) begin
            if (r_s1_in_a && (r_s1_cidx == r_s1_idx)) begin
                // equal halves: this value must already be there once more
                pair = (new_cnt > CNT_BITS'(1));
                same = pair;
            end else begin
                pair = (cnt_b != '0);
            end
        end
    end

    always_comb begin
        if (r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = {STAMP_NONE, {CNT_BITS{1'b0}}};
        end else begin
            ram_we    = s1_wr;
            ram_waddr = r_s1_idx;
            ram_wdata = {r_s1_epoch, new_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= s1_wr && (r_state == ST_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= r_s1_idx;
        r_fw_word <= {r_s1_epoch, new_cnt};
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    logic [RES_W-1:0] res_in, res_out;

    assign res_in  = {pair, same, r_s1_value, r_s1_comp, !r_s1_in_a};
    assign q_pop   = o_out_valid && i_out_ready;
    assign res_out = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({r_s1_valid, q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q[r_wp] <= res_in;
        end
    end

    assign o_out_valid    = (r_cnt != '0);
    assign o_pair_found   = res_out[RES_W-1];
    assign o_same_value   = res_out[RES_W-2];
    assign o_first_value  = res_out[RES_W-3 -: VB];
    assign o_second_value = res_out[VB+1:1];
    assign o_out_of_range = res_out[0];

endmodule

`default_nettype wire

// ===== hdl/spsd_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module spsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/spsd_checker.sv =====
// Port-level assertions for the pair-sum detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spsd_checker #(
    parameter int VALUE_BITS = spsd_pkg::DEF_VALUE_BITS
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         o_pair_found,
    input wire logic                         o_same_value,
    input wire logic signed [VALUE_BITS-1:0] o_first_value,
    input wire logic signed [VALUE_BITS:0]   o_second_value,
    input wire logic                         o_out_of_range
);

    // reset empties the result queue
    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // the clearing pass after reset holds off input
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input taken during clearing pass");

    a_same_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pair_found || !o_same_value))
        else $error("equal-value flag without a pair");

    // an uncounted value cannot pair with itself
    a_oor_not_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> !o_same_value)
        else $error("out-of-range value reported as equal pair");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_first_value)
            && $stable(o_second_value) && $stable(o_pair_found)))
        else $error("stalled result changed");

endmodule

bind streaming_pair_sum_detector spsd_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_spsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pair_found   (o_pair_found),
    .o_same_value   (o_same_value),
    .o_first_value  (o_first_value),
    .o_second_value (o_second_value),
    .o_out_of_range (o_out_of_range)
);

`default_nettype wire
